FILE: rtl/pwsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pyramid window scan generator package
// Shared widths, register indexes, divider handshake types and helpers.
// ----------------------------------------------------------------------------
package pwsg_pkg;

	localparam int DIM_W           = 13;
	localparam int COORD_W         = 12;
	localparam int WIN_W           = 8;
	localparam int RATIO_W         = 14;
	localparam int LEVEL_W         = 16;
	localparam int SPAN_W          = 20;
	localparam int RATIO_FRAC_BITS = 12;
	localparam int NUM_W           = 25;
	localparam int DEN_W           = 14;
	localparam int DIV_CNT_W       = $clog2(NUM_W);
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 14;
	localparam int IN_DATA_W       = 8;
	localparam int OUT_DATA_W      = 136;

	localparam logic [DIM_W-1:0]   MAX_DIM   = 13'd4096;
	localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIG_WIDTH  = 3'd0,
		CFG_ORIG_HEIGHT = 3'd1,
		CFG_MAX_INIT    = 3'd2,
		CFG_WIN_WIDTH   = 3'd3,
		CFG_WIN_HEIGHT  = 3'd4,
		CFG_STEP_SIZE   = 3'd5,
		CFG_SCALE_RATIO = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [NUM_W-1:0]  quo;
		logic [DEN_W-1:0]  rem;
	} div_rsp_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > MAX_DIM)
			r = MAX_DIM;
		return r;
	endfunction

	function automatic logic [WIN_W-1:0] nz_win(input logic [WIN_W-1:0] v);
		return (v == '0) ? WIN_W'(1) : v;
	endfunction

	function automatic logic [RATIO_W-1:0] eff_ratio(input logic [RATIO_W-1:0] v);
		return (v <= RATIO_ONE) ? RATIO_ONE + RATIO_W'(1) : v;
	endfunction

endpackage

FILE: rtl/pwsg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pyramid window scan generator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwsg_div (
	input  logic                clk,
	input  logic                arst_n,
	input  pwsg_pkg::div_req_t  req,
	output pwsg_pkg::div_rsp_t  rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [pwsg_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [pwsg_pkg::NUM_W-1:0]          quo_q;
	logic [pwsg_pkg::DEN_W-1:0]          rem_q;
	logic [pwsg_pkg::DEN_W-1:0]          den_q;
	logic [pwsg_pkg::DEN_W:0]            trial;
	logic [pwsg_pkg::DEN_W:0]            diff;
	logic                                fits;

	assign trial = {rem_q, quo_q[pwsg_pkg::NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= pwsg_pkg::DIV_CNT_W'(pwsg_pkg::NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[pwsg_pkg::NUM_W-2:0], fits};
			rem_q <= fits ? diff[pwsg_pkg::DEN_W-1:0] : trial[pwsg_pkg::DEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

FILE: rtl/pyramid_window_scan_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pyramid window scan generator
// Steps a detection window over an image pyramid, one window per item.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata[0] restart
//  m_axis    out        tuser valid_res; tdata window, level and mapped sizes
//  cfg       in         write enable, register index, register data
//
//  Every coordinate division runs on one shared 25-step divider. A plain item
//  maps its window back to the original image; a restart first rescales and
//  sets spans, a new level shrinks the size. Reset leaves the scan finished
//  until a restart item. The next item is taken while the last result waits.
// ----------------------------------------------------------------------------
module pyramid_window_scan_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [pwsg_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // restart
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// win_col, win_row, level, orig_col, orig_row, orig_win_width,
	// orig_win_height, level_width, level_height, zero fill
	output logic [pwsg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tuser,  // valid_res
	input  logic                                cfg_we,
	input  logic [pwsg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pwsg_pkg::CFG_DATA_W-1:0]     cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_WAIT = 5'b00100,
		ST_PUSH = 5'b01000,
		ST_STEP = 5'b10000
	} state_t;

	typedef enum logic [3:0] {
		OP_SCALE    = 4'd0,
		OP_SPAN_W   = 4'd1,
		OP_SPAN_H   = 4'd2,
		OP_ORIG_COL = 4'd3,
		OP_ORIG_ROW = 4'd4,
		OP_LVL_W    = 4'd5,
		OP_LVL_H    = 4'd6,
		OP_LSPAN_W  = 4'd7,
		OP_LSPAN_H  = 4'd8
	} op_t;

	localparam int PROD_W = pwsg_pkg::DIM_W + pwsg_pkg::RATIO_W;
	localparam int STEP_W = pwsg_pkg::COORD_W + 2;

	logic [pwsg_pkg::DIM_W-1:0]    ow_raw_q, oh_raw_q, mx_raw_q;
	logic [pwsg_pkg::WIN_W-1:0]    ww_raw_q, wh_raw_q, st_raw_q;
	logic [pwsg_pkg::RATIO_W-1:0]  ratio_raw_q;

	logic [pwsg_pkg::DIM_W-1:0]    ow, oh, mx;
	logic [pwsg_pkg::WIN_W-1:0]    ww, wh, st;
	logic [pwsg_pkg::RATIO_W-1:0]  ratio;

	state_t                        state_q;
	op_t                           op_q;
	logic [pwsg_pkg::DIM_W-1:0]    cur_w_q, cur_h_q;
	logic [pwsg_pkg::COORD_W-1:0]  pos_col_q, pos_row_q;
	logic [pwsg_pkg::LEVEL_W-1:0]  level_q;
	logic [pwsg_pkg::SPAN_W-1:0]   span_w_q, span_h_q;
	logic                          fin_q;
	logic [pwsg_pkg::COORD_W-1:0]  ocol_q, orow_q;
	logic [pwsg_pkg::DIM_W-1:0]    lq_w_q;
	logic                          lr_w_q;

	logic                          out_valid_q;
	logic                          out_flag_q;
	logic [pwsg_pkg::COORD_W-1:0]  out_col_q, out_row_q, out_ocol_q, out_orow_q;
	logic [pwsg_pkg::LEVEL_W-1:0]  out_level_q;
	logic [pwsg_pkg::SPAN_W-1:0]   out_sw_q, out_sh_q;
	logic [pwsg_pkg::DIM_W-1:0]    out_lw_q, out_lh_q;

	pwsg_pkg::div_req_t            div_req;
	pwsg_pkg::div_rsp_t            div_rsp;

	logic [pwsg_pkg::DIM_W-1:0]    mul_a;
	logic [pwsg_pkg::RATIO_W-1:0]  mul_b;
	logic [PROD_W-1:0]             prod;
	logic [pwsg_pkg::DEN_W-1:0]    den_sel;

	logic                          in_acc;
	logic                          push;
	logic                          need_scale;
	logic                          tall;
	logic [STEP_W-1:0]             col_next, row_next;
	logic                          col_ok, row_ok;
	logic [pwsg_pkg::DIM_W-1:0]    q_dim;
	logic [pwsg_pkg::SPAN_W-1:0]   q_span;
	logic                          lvl_fits;

	assign ow    = pwsg_pkg::clamp_dim(ow_raw_q);
	assign oh    = pwsg_pkg::clamp_dim(oh_raw_q);
	assign mx    = pwsg_pkg::clamp_dim(mx_raw_q);
	assign ww    = pwsg_pkg::nz_win(ww_raw_q);
	assign wh    = pwsg_pkg::nz_win(wh_raw_q);
	assign st    = pwsg_pkg::nz_win(st_raw_q);
	assign ratio = pwsg_pkg::eff_ratio(ratio_raw_q);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign push          = (state_q == ST_PUSH) && (!out_valid_q || m_axis_tready);
	assign need_scale    = (ow > mx) || (oh > mx);
	assign tall          = oh > ow;

	assign col_next = STEP_W'(pos_col_q) + STEP_W'(ww) + STEP_W'(st);
	assign row_next = STEP_W'(pos_row_q) + STEP_W'(wh) + STEP_W'(st);
	assign col_ok   = col_next <= STEP_W'(cur_w_q);
	assign row_ok   = row_next <= STEP_W'(cur_h_q);

	assign q_dim    = div_rsp.quo[pwsg_pkg::DIM_W-1:0];
	assign q_span   = div_rsp.quo[pwsg_pkg::SPAN_W-1:0];
	assign lvl_fits = (lq_w_q >= pwsg_pkg::DIM_W'(ww)) && (q_dim >= pwsg_pkg::DIM_W'(wh));

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		den_sel = pwsg_pkg::DEN_W'(1);
		unique case (op_q)
			OP_SCALE: begin
				mul_a   = tall ? ow : oh;
				mul_b   = pwsg_pkg::RATIO_W'(mx);
				den_sel = pwsg_pkg::DEN_W'(tall ? oh : ow);
			end
			OP_SPAN_W, OP_LSPAN_W: begin
				mul_a   = ow;
				mul_b   = pwsg_pkg::RATIO_W'(ww);
				den_sel = pwsg_pkg::DEN_W'(cur_w_q);
			end
			OP_SPAN_H, OP_LSPAN_H: begin
				mul_a   = oh;
				mul_b   = pwsg_pkg::RATIO_W'(wh);
				den_sel = pwsg_pkg::DEN_W'(cur_h_q);
			end
			OP_ORIG_COL: begin
				mul_a   = pwsg_pkg::DIM_W'(pos_col_q);
				mul_b   = pwsg_pkg::RATIO_W'(ow);
				den_sel = pwsg_pkg::DEN_W'(cur_w_q);
			end
			OP_ORIG_ROW: begin
				mul_a   = pwsg_pkg::DIM_W'(pos_row_q);
				mul_b   = pwsg_pkg::RATIO_W'(oh);
				den_sel = pwsg_pkg::DEN_W'(cur_h_q);
			end
			OP_LVL_W: begin
				mul_a   = cur_w_q;
				mul_b   = pwsg_pkg::RATIO_ONE;
				den_sel = ratio;
			end
			OP_LVL_H: begin
				mul_a   = cur_h_q;
				mul_b   = pwsg_pkg::RATIO_ONE;
				den_sel = ratio;
			end
			default: begin
				mul_a   = '0;
				mul_b   = '0;
				den_sel = pwsg_pkg::DEN_W'(1);
			end
		endcase
	end

	assign prod          = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign div_req.start = (state_q == ST_LOAD);
	assign div_req.num   = prod[pwsg_pkg::NUM_W-1:0];
	assign div_req.den   = den_sel;

	pwsg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_raw_q    <= 13'd640;
			oh_raw_q    <= 13'd480;
			mx_raw_q    <= 13'd4096;
			ww_raw_q    <= 8'd36;
			wh_raw_q    <= 8'd36;
			st_raw_q    <= 8'd1;
			ratio_raw_q <= 14'd4915;
		end else if (cfg_we) begin
			unique case (pwsg_pkg::cfg_idx_t'(cfg_index))
				pwsg_pkg::CFG_ORIG_WIDTH:  ow_raw_q    <= cfg_data[pwsg_pkg::DIM_W-1:0];
				pwsg_pkg::CFG_ORIG_HEIGHT: oh_raw_q    <= cfg_data[pwsg_pkg::DIM_W-1:0];
				pwsg_pkg::CFG_MAX_INIT:    mx_raw_q    <= cfg_data[pwsg_pkg::DIM_W-1:0];
				pwsg_pkg::CFG_WIN_WIDTH:   ww_raw_q    <= cfg_data[pwsg_pkg::WIN_W-1:0];
				pwsg_pkg::CFG_WIN_HEIGHT:  wh_raw_q    <= cfg_data[pwsg_pkg::WIN_W-1:0];
				pwsg_pkg::CFG_STEP_SIZE:   st_raw_q    <= cfg_data[pwsg_pkg::WIN_W-1:0];
				pwsg_pkg::CFG_SCALE_RATIO: ratio_raw_q <= cfg_data[pwsg_pkg::RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_SCALE;
			cur_w_q   <= '0;
			cur_h_q   <= '0;
			pos_col_q <= '0;
			pos_row_q <= '0;
			level_q   <= '0;
			span_w_q  <= '0;
			span_h_q  <= '0;
			fin_q     <= 1'b1;
			ocol_q    <= '0;
			orow_q    <= '0;
			lq_w_q    <= '0;
			lr_w_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_axis_tdata[0]) begin
							cur_w_q <= ow;
							cur_h_q <= oh;
							op_q    <= need_scale ? OP_SCALE : OP_SPAN_W;
							state_q <= ST_LOAD;
						end else if (fin_q) begin
							state_q <= ST_PUSH;
						end else begin
							op_q    <= OP_ORIG_COL;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_rsp.done) begin
						unique case (op_q)
							OP_SCALE: begin
								if (tall) begin
									cur_h_q <= mx;
									cur_w_q <= (q_dim == '0) ? pwsg_pkg::DIM_W'(1) : q_dim;
								end else begin
									cur_w_q <= mx;
									cur_h_q <= (q_dim == '0) ? pwsg_pkg::DIM_W'(1) : q_dim;
								end
								op_q    <= OP_SPAN_W;
								state_q <= ST_LOAD;
							end
							OP_SPAN_W: begin
								span_w_q <= q_span;
								op_q     <= OP_SPAN_H;
								state_q  <= ST_LOAD;
							end
							OP_SPAN_H: begin
								span_h_q  <= q_span;
								pos_col_q <= '0;
								pos_row_q <= '0;
								level_q   <= '0;
								if ((pwsg_pkg::DIM_W'(ww) > cur_w_q) ||
								    (pwsg_pkg::DIM_W'(wh) > cur_h_q)) begin
									fin_q   <= 1'b1;
									state_q <= ST_PUSH;
								end else begin
									fin_q   <= 1'b0;
									op_q    <= OP_ORIG_COL;
									state_q <= ST_LOAD;
								end
							end
							OP_ORIG_COL: begin
								ocol_q  <= div_rsp.quo[pwsg_pkg::COORD_W-1:0];
								op_q    <= OP_ORIG_ROW;
								state_q <= ST_LOAD;
							end
							OP_ORIG_ROW: begin
								orow_q  <= div_rsp.quo[pwsg_pkg::COORD_W-1:0];
								state_q <= ST_PUSH;
							end
							OP_LVL_W: begin
								lq_w_q  <= q_dim;
								lr_w_q  <= (div_rsp.rem != '0);
								op_q    <= OP_LVL_H;
								state_q <= ST_LOAD;
							end
							OP_LVL_H: begin
								if (lvl_fits) begin
									cur_w_q <= lq_w_q + pwsg_pkg::DIM_W'(lr_w_q);
									cur_h_q <= q_dim + pwsg_pkg::DIM_W'(div_rsp.rem != '0);
									op_q    <= OP_LSPAN_W;
									state_q <= ST_LOAD;
								end else begin
									fin_q   <= 1'b1;
									state_q <= ST_IDLE;
								end
							end
							OP_LSPAN_W: begin
								span_w_q <= q_span;
								op_q     <= OP_LSPAN_H;
								state_q  <= ST_LOAD;
							end
							OP_LSPAN_H: begin
								span_w_q  <= (span_w_q > q_span) ? span_w_q : q_span;
								span_h_q  <= (span_w_q > q_span) ? span_w_q : q_span;
								pos_col_q <= '0;
								pos_row_q <= '0;
								if (level_q != '1)
									level_q <= level_q + 1'b1;
								state_q <= ST_IDLE;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_PUSH: begin
					if (push)
						state_q <= fin_q ? ST_IDLE : ST_STEP;
				end
				ST_STEP: begin
					if (col_ok) begin
						pos_col_q <= pos_col_q + pwsg_pkg::COORD_W'(st);
						state_q   <= ST_IDLE;
					end else if (row_ok) begin
						pos_col_q <= '0;
						pos_row_q <= pos_row_q + pwsg_pkg::COORD_W'(st);
						state_q   <= ST_IDLE;
					end else begin
						op_q    <= OP_LVL_W;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_flag_q <= !fin_q;
			if (fin_q) begin
				out_col_q   <= '0;
				out_row_q   <= '0;
				out_level_q <= '0;
				out_ocol_q  <= '0;
				out_orow_q  <= '0;
				out_sw_q    <= '0;
				out_sh_q    <= '0;
				out_lw_q    <= '0;
				out_lh_q    <= '0;
			end else begin
				out_col_q   <= pos_col_q;
				out_row_q   <= pos_row_q;
				out_level_q <= level_q;
				out_ocol_q  <= ocol_q;
				out_orow_q  <= orow_q;
				out_sw_q    <= span_w_q;
				out_sh_q    <= span_h_q;
				out_lw_q    <= cur_w_q;
				out_lh_q    <= cur_h_q;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_flag_q;
	assign m_axis_tdata  = {6'b0, out_lh_q, out_lw_q, out_sh_q, out_sw_q, out_orow_q,
	                        out_ocol_q, out_level_q, out_row_q, out_col_q};

endmodule
